[rtl/tccs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared constants, command codes and helpers of the text console unit.
// ----------------------------------------------------------------------------
package tccs_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	localparam int CMD_W  = 2;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CELL_W = CHAR_W + ATTR_W;

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 32;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
	localparam logic [CHAR_W-1:0] FILL_CODE    = 8'd0;
	localparam logic [ATTR_W-1:0] BLANK_RESET  = 8'h0F;

	localparam logic [CMD_W-1:0] CMD_WRITE_CUR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE_AT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ      = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd3;

	typedef struct packed {
		logic adv;
		logic home;
		logic use_req;
	} cur_ctl_t;

	function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W-1:0] row);
		return (row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : row;
	endfunction

	function automatic logic [COL_W-1:0] clamp_col(input logic [COL_W-1:0] col);
		return (col > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : col;
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		logic [ADDR_W-1:0] r;
		r = ADDR_W'(row);
		return r * ADDR_W'(COLUMNS) + ADDR_W'(col);
	endfunction

endpackage
`default_nettype wire

[rtl/tccs_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module tccs_ram #(
	parameter int DATA_W = 16,
	parameter int DEPTH  = 2000,
	parameter int ADDR_W = 11
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/tccs_cursor.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_cursor
// Cursor position register with base selection and advance logic.
// ----------------------------------------------------------------------------
module tccs_cursor (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire tccs_pkg::cur_ctl_t      ctl,
	input  wire logic                    newline,
	input  wire logic [tccs_pkg::ROW_W-1:0] req_row,
	input  wire logic [tccs_pkg::COL_W-1:0] req_col,
	output logic      [tccs_pkg::ROW_W-1:0] base_row,
	output logic      [tccs_pkg::COL_W-1:0] base_col,
	output logic      [tccs_pkg::ROW_W-1:0] nxt_row,
	output logic      [tccs_pkg::COL_W-1:0] nxt_col,
	output logic      [tccs_pkg::ROW_W-1:0] cur_row,
	output logic      [tccs_pkg::COL_W-1:0] cur_col,
	output logic                         wrap
);
	import tccs_pkg::*;

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;

	always_comb begin
		base_row = ctl.use_req ? clamp_row(req_row) : row_q;
		base_col = ctl.use_req ? clamp_col(req_col) : col_q;
		wrap     = 1'b0;
		nxt_row  = base_row;
		nxt_col  = base_col + COL_W'(1);
		if (newline || base_col == COL_W'(COLUMNS - 1)) begin
			nxt_col = '0;
			if (base_row == ROW_W'(ROWS - 1)) begin
				wrap = 1'b1;
			end else begin
				nxt_row = base_row + ROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (ctl.home) begin
			row_q <= '0;
			col_q <= '0;
		end else if (ctl.adv) begin
			row_q <= nxt_row;
			col_q <= nxt_col;
		end
	end

	assign cur_row = row_q;
	assign cur_col = col_q;

endmodule
`default_nettype wire

[rtl/text_console_cursor_scroll_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_unit
// Character-cell text console with cursor and scroll, and write, read and clear commands.
// ----------------------------------------------------------------------------
// Requests enter on the s_* stream: tuser holds the command, tdata the
// character, attribute, row and column. Every request returns exactly one
// response on the m_* stream with the read cell, the new cursor position and
// a scroll flag. The cfg_* channel writes the blank attribute; it is always
// ready and should only be written while no request is in flight.
// A write or read request is accepted in ST_IDLE (reads address the cell RAM
// here) and executes in ST_EXEC against the single write port of the cell RAM;
// a request that does not scroll waits there until the output register is free.
// A write that runs past the last cell scrolls: one priming read (ST_PRIME) and
// then ST_SCROLL walks the cell RAM one cell per cycle.
// A clear request walks every cell of the cell RAM.
// After reset the unit clears every cell of the cell RAM, with s_tready low,
// before it takes its first request.
// The response sits in an output register; a new request is accepted while
// it waits, and a finished request holds in place until m_tready frees it.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// character[7:0], attribute[15:8], row[20:16], column[27:21]
	input  wire logic [tccs_pkg::S_TDATA_W-1:0] s_tdata,
	// command[1:0]
	input  wire logic [tccs_pkg::CMD_W-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// cell_char[7:0], cell_attr[15:8], cursor_row[20:16], cursor_col[27:21],
	// scrolled[28]
	output logic      [tccs_pkg::M_TDATA_W-1:0] m_tdata,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [tccs_pkg::ATTR_W-1:0]    cfg_data
);
	import tccs_pkg::*;

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_EXEC   = 3'd2;
	localparam logic [2:0] ST_CLEAR  = 3'd3;
	localparam logic [2:0] ST_PRIME  = 3'd4;
	localparam logic [2:0] ST_SCROLL = 3'd5;
	localparam logic [2:0] ST_FINAL  = 3'd6;

	localparam int DATA_USED = CHAR_W + ATTR_W + ROW_W + COL_W + 1;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [ATTR_W-1:0] blank_q;
	logic              scroll_q;
	logic              m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic [CMD_W-1:0]  cmd_q;
	logic [CHAR_W-1:0] ch_q;
	logic [ATTR_W-1:0] attr_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;

	logic [CHAR_W-1:0] in_ch;
	logic [ATTR_W-1:0] in_attr;
	logic [ROW_W-1:0]  in_row;
	logic [COL_W-1:0]  in_col;
	logic              accept;
	logic              out_free;
	logic              last_cell;
	logic              is_write;
	logic              newline;
	logic              proceed;

	cur_ctl_t          cur_ctl;
	logic [ROW_W-1:0]  base_row;
	logic [COL_W-1:0]  base_col;
	logic [ROW_W-1:0]  nxt_row;
	logic [COL_W-1:0]  nxt_col;
	logic [ROW_W-1:0]  cur_row;
	logic [COL_W-1:0]  cur_col;
	logic              wrap;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;
	logic [ADDR_W:0]   scroll_rd;

	logic              load_out;
	logic [CELL_W-1:0] res_cell;
	logic              res_scroll;
	logic [ROW_W-1:0]  res_row;
	logic [COL_W-1:0]  res_col;

	assign in_ch   = s_tdata[CHAR_W-1:0];
	assign in_attr = s_tdata[CHAR_W +: ATTR_W];
	assign in_row  = s_tdata[CHAR_W+ATTR_W +: ROW_W];
	assign in_col  = s_tdata[CHAR_W+ATTR_W+ROW_W +: COL_W];

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;
	assign last_cell = (cnt_q == ADDR_W'(CELL_COUNT - 1));
	assign is_write  = (cmd_q == CMD_WRITE_CUR) || (cmd_q == CMD_WRITE_AT);
	assign newline   = (ch_q == NEWLINE_CODE);
	assign proceed   = wrap || out_free;
	assign scroll_rd = (ADDR_W+1)'(cnt_q) + (ADDR_W+1)'(COLUMNS + 1);

	always_comb begin
		cur_ctl.use_req = (cmd_q != CMD_WRITE_CUR);
		cur_ctl.adv     = (state_q == ST_EXEC) && is_write && proceed;
		cur_ctl.home    = (state_q == ST_EXEC) && (cmd_q == CMD_CLEAR);
	end

	tccs_cursor u_cursor (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (cur_ctl),
		.newline  (newline),
		.req_row  (row_q),
		.req_col  (col_q),
		.base_row (base_row),
		.base_col (base_col),
		.nxt_row  (nxt_row),
		.nxt_col  (nxt_col),
		.cur_row  (cur_row),
		.cur_col  (cur_col),
		.wrap     (wrap)
	);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				ram_re    = accept && (s_tuser == CMD_READ);
				ram_raddr = cell_addr(clamp_row(in_row), clamp_col(in_col));
			end
			ST_PRIME: begin
				ram_re    = 1'b1;
				ram_raddr = ADDR_W'(COLUMNS);
			end
			ST_SCROLL: begin
				ram_re    = (scroll_rd < (ADDR_W+1)'(CELL_COUNT));
				ram_raddr = scroll_rd[ADDR_W-1:0];
			end
			default: begin
				ram_re    = 1'b0;
				ram_raddr = '0;
			end
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = {blank_q, SPACE_CODE};
		case (state_q)
			ST_EXEC: begin
				ram_we    = is_write && proceed && !newline;
				ram_waddr = cell_addr(base_row, base_col);
				ram_wdata = {attr_q, ch_q};
			end
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = {BLANK_RESET, SPACE_CODE};
			end
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = {blank_q, SPACE_CODE};
			end
			ST_SCROLL: begin
				ram_we    = 1'b1;
				ram_wdata = (cnt_q < ADDR_W'(CELL_COUNT - COLUMNS)) ? ram_rdata
					: {blank_q, FILL_CODE};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	tccs_ram #(
		.DATA_W (CELL_W),
		.DEPTH  (CELL_COUNT),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		load_out   = 1'b0;
		res_cell   = '0;
		res_scroll = 1'b0;
		res_row    = cur_row;
		res_col    = cur_col;
		case (state_q)
			ST_EXEC: begin
				if (cmd_q == CMD_READ) begin
					load_out = out_free;
					res_cell = ram_rdata;
				end else if (is_write) begin
					load_out = !wrap && out_free;
					res_row  = nxt_row;
					res_col  = nxt_col;
				end
			end
			ST_FINAL: begin
				load_out   = out_free;
				res_scroll = scroll_q;
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= s_tuser;
			ch_q   <= in_ch;
			attr_q <= in_attr;
			row_q  <= in_row;
			col_q  <= in_col;
		end
		if (load_out) begin
			m_tdata_q <= {(M_TDATA_W - DATA_USED)'(0), res_scroll, res_col, res_row,
				res_cell};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			cnt_q      <= '0;
			blank_q    <= BLANK_RESET;
			scroll_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				blank_q <= cfg_data;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (last_cell) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					cnt_q <= '0;
					if (cmd_q == CMD_CLEAR) begin
						scroll_q <= 1'b0;
						state_q  <= ST_CLEAR;
					end else if (is_write && wrap) begin
						scroll_q <= 1'b1;
						state_q  <= ST_PRIME;
					end else if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (last_cell) begin
						state_q <= ST_FINAL;
					end
				end
				ST_PRIME: begin
					state_q <= ST_SCROLL;
				end
				ST_SCROLL: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (last_cell) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// A walk over the cell RAM never overlaps with taking a new request.
	a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL || state_q == ST_CLEAR || state_q == ST_INIT) |-> !s_tready)
		else $error("request taken during a cell RAM walk");

	// A scrolled response always leaves the cursor at the start of the bottom row.
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[CHAR_W+ATTR_W+ROW_W+COL_W]) |->
		(m_tdata[CHAR_W+ATTR_W +: ROW_W] == ROW_W'(ROWS - 1) &&
		 m_tdata[CHAR_W+ATTR_W+ROW_W +: COL_W] == '0))
		else $error("scrolled response with cursor off the bottom row start");

	// The cell RAM is never written outside the screen.
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ram_waddr < ADDR_W'(CELL_COUNT)))
		else $error("cell RAM write beyond the last cell");

	// A response held back by the receiver keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("stalled response changed");

endmodule
`default_nettype wire

[test/tb_text_console_cursor_scroll_unit.sv]
// ----------------------------------------------------------------------------
// tb_text_console_cursor_scroll_unit
// Self-checking bench for the text console unit. Requests are streamed in with
// random gaps and response stalls. A cell-accurate console model predicts
// every response, including scrolls and clears, and each response is checked
// field by field. The blank attribute is changed between phases, including
// its extreme values.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_scroll_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import tccs_pkg::*;

	typedef struct packed {
		logic       scrolled;
		logic [6:0] col;
		logic [4:0] row;
		logic [7:0] attr;
		logic [7:0] ch;
	} console_reply_t;

	class console_scoreboard;
		logic [CELL_W-1:0] cells [CELL_COUNT];
		int unsigned       cursor;
		logic [7:0]        blank_attr;
		console_reply_t    console_replies [$];
		int unsigned       errors;

		function new();
			blank_attr = BLANK_RESET;
			cursor     = 0;
			errors     = 0;
			fill_blank();
		endfunction

		function void fill_blank();
			int i;
			for (i = 0; i < CELL_COUNT; i++) begin
				cells[i] = {blank_attr, SPACE_CODE};
			end
		endfunction

		function int unsigned cell_index(logic [4:0] row, logic [6:0] col);
			int unsigned r;
			int unsigned c;
			r = (row > ROWS - 1) ? ROWS - 1 : row;
			c = (col > COLUMNS - 1) ? COLUMNS - 1 : col;
			return r * COLUMNS + c;
		endfunction

		function int pending();
			return console_replies.size();
		endfunction

		function void apply_request(logic [1:0] cmd, logic [7:0] ch, logic [7:0] attr,
				logic [4:0] row, logic [6:0] col);
			int unsigned    pos;
			int             i;
			console_reply_t r;
			r = '0;
			if (cmd == CMD_WRITE_CUR || cmd == CMD_WRITE_AT) begin
				pos = (cmd == CMD_WRITE_CUR) ? cursor : cell_index(row, col);
				if (pos >= CELL_COUNT) begin
					pos = 0;
				end
				if (ch == NEWLINE_CODE) begin
					pos = (pos / COLUMNS) * COLUMNS + COLUMNS - 1;
				end else begin
					cells[pos] = {attr, ch};
				end
				pos++;
				if (pos >= CELL_COUNT) begin
					for (i = 0; i < CELL_COUNT - COLUMNS; i++) begin
						cells[i] = cells[i + COLUMNS];
					end
					for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
						cells[i] = {blank_attr, FILL_CODE};
					end
					pos -= COLUMNS;
					r.scrolled = 1'b1;
				end
				cursor = pos;
			end else if (cmd == CMD_READ) begin
				{r.attr, r.ch} = cells[cell_index(row, col)];
			end else begin
				fill_blank();
				cursor = 0;
			end
			r.row = 5'(cursor / COLUMNS);
			r.col = 7'(cursor % COLUMNS);
			console_replies.push_back(r);
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want,
					got);
			end
		endfunction

		function void compare_reply(logic [M_TDATA_W-1:0] data);
			console_reply_t got;
			console_reply_t want;
			got = data[28:0];
			if (console_replies.size() == 0) begin
				errors++;
				$display("%0t: response %h arrived, expected none, actual %h", $time, data,
					data);
				return;
			end
			want = console_replies.pop_front();
			check_field("cell_char", want.ch, got.ch);
			check_field("cell_attr", want.attr, got.attr);
			check_field("cursor_row", want.row, got.row);
			check_field("cursor_col", want.col, got.col);
			check_field("scrolled", want.scrolled, got.scrolled);
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT   = 10000;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS      = 150;

	typedef struct {
		logic [1:0]  cmd;
		logic [7:0]  ch;
		logic [7:0]  attr;
		logic [4:0]  row;
		logic [6:0]  col;
		int unsigned gap;
	} console_req_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic [S_TDATA_W-1:0]   s_tdata   = '0;
	logic [CMD_W-1:0]       s_tuser   = '0;
	logic                   m_tready  = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic [ATTR_W-1:0]      cfg_data  = '0;
	logic                   s_tready;
	logic                   m_tvalid;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   cfg_ready;

	console_scoreboard sb = new();
	console_req_t      request_q [$];
	int unsigned       queued_count   = 0;
	int unsigned       accepted_count = 0;
	int unsigned       idle_cycles    = 0;
	bit                hold_off_request = 1'b0;

	text_console_cursor_scroll_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // character, attribute, row, column
		.s_tuser   (s_tuser),   // command
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // cell_char, cell_attr, cursor_row, cursor_col, scrolled
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic push_req(logic [1:0] cmd, logic [7:0] ch, logic [7:0] attr,
			logic [4:0] row, logic [6:0] col, bit idle);
		console_req_t req;
		while (request_q.size() >= 4) @(posedge clk);
		req.cmd  = cmd;
		req.ch   = ch;
		req.attr = attr;
		req.row  = row;
		req.col  = col;
		req.gap  = idle ? $urandom_range(0, 14) : 0;
		request_q.push_back(req);
		queued_count++;
	endtask

	task automatic random_req(bit idle);
		int unsigned pick;
		logic [1:0]  cmd;
		logic [7:0]  ch;
		logic [4:0]  row;
		logic [6:0]  col;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			cmd = CMD_WRITE_CUR;
		end else if (pick < 72) begin
			cmd = CMD_WRITE_AT;
		end else if (pick < 97) begin
			cmd = CMD_READ;
		end else begin
			cmd = CMD_CLEAR;
		end
		ch  = ($urandom_range(0, 4) == 0) ? NEWLINE_CODE : 8'($urandom);
		row = $urandom_range(0, 1) ? 5'($urandom_range(22, 31)) : 5'($urandom);
		col = $urandom_range(0, 1) ? 7'($urandom_range(75, 127)) : 7'($urandom);
		push_req(cmd, ch, 8'($urandom), row, col, idle);
	endtask

	task automatic wait_idle();
		while (accepted_count != queued_count || sb.pending() != 0) @(posedge clk);
	endtask

	task automatic set_blank_attr(logic [7:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.blank_attr = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : request_driver
		console_req_t req;
		wait (arst_n === 1'b1);
		forever begin
			if (request_q.size() == 0) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end else begin
				req = request_q.pop_front();
				if (req.gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (req.gap) @(posedge clk);
				end
				s_tvalid <= 1'b1;
				s_tuser  <= req.cmd;
				s_tdata  <= {4'b0, req.col, req.row, req.attr, req.ch};
				do @(posedge clk); while (s_tready !== 1'b1);
				sb.apply_request(req.cmd, req.ch, req.attr, req.row, req.col);
				accepted_count++;
			end
		end
	end

	initial begin : response_sink
		int unsigned stall;
		int unsigned replies;
		replies = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				stall = LONG_HOLD_CYCLES;
			end else begin
				stall = ((replies / 40) % 3 == 1) ? 0 : $urandom_range(0, 14);
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			sb.compare_reply(m_tdata);
			replies++;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : main_sequence
		int   phase;
		int   n;
		logic [7:0] phase_blank;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset contents, clamped coordinates, plain writes and newlines.
		push_req(CMD_READ, 8'h00, 8'h00, 5'd0, 7'd0, 1'b1);
		push_req(CMD_READ, 8'h00, 8'h00, 5'd31, 7'd127, 1'b1);
		push_req(CMD_WRITE_CUR, 8'h48, 8'h00, 5'd0, 7'd0, 1'b1);
		push_req(CMD_WRITE_CUR, 8'hFF, 8'hFF, 5'd31, 7'd127, 1'b0);
		push_req(CMD_WRITE_CUR, 8'h00, 8'h5A, 5'd0, 7'd0, 1'b0);
		push_req(CMD_WRITE_CUR, NEWLINE_CODE, 8'h33, 5'd0, 7'd0, 1'b1);
		push_req(CMD_WRITE_AT, 8'h78, 8'hA5, 5'd3, 7'd40, 1'b1);
		push_req(CMD_WRITE_AT, NEWLINE_CODE, 8'h11, 5'd0, 7'd5, 1'b1);
		push_req(CMD_READ, 8'h00, 8'h00, 5'd3, 7'd40, 1'b0);
		push_req(CMD_READ, 8'h00, 8'h00, 5'd0, 7'd2, 1'b1);

		// Running past the last cell by each path scrolls the screen.
		push_req(CMD_WRITE_AT, 8'h61, 8'h71, 5'd24, 7'd78, 1'b1);
		push_req(CMD_WRITE_CUR, 8'h62, 8'h72, 5'd0, 7'd0, 1'b0);
		push_req(CMD_READ, 8'h00, 8'h00, 5'd23, 7'd78, 1'b1);
		push_req(CMD_READ, 8'h00, 8'h00, 5'd24, 7'd0, 1'b1);
		push_req(CMD_WRITE_AT, 8'h7A, 8'h80, 5'd31, 7'd127, 1'b1);
		push_req(CMD_WRITE_AT, NEWLINE_CODE, 8'h01, 5'd24, 7'd10, 1'b0);
		push_req(CMD_WRITE_CUR, NEWLINE_CODE, 8'h02, 5'd0, 7'd0, 1'b1);
		push_req(CMD_READ, 8'h00, 8'h00, 5'd22, 7'd79, 1'b1);
		push_req(CMD_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0, 1'b1);
		push_req(CMD_READ, 8'h00, 8'h00, 5'd12, 7'd40, 1'b0);
		push_req(CMD_READ, 8'h00, 8'h00, 5'd24, 7'd79, 1'b1);

		set_blank_attr(8'h00);
		push_req(CMD_WRITE_AT, 8'h71, 8'hC3, 5'd24, 7'd79, 1'b1);
		push_req(CMD_READ, 8'h00, 8'h00, 5'd24, 7'd5, 1'b1);
		set_blank_attr(8'hFF);
		push_req(CMD_CLEAR, 8'hFF, 8'hFF, 5'd31, 7'd127, 1'b1);
		push_req(CMD_READ, 8'h00, 8'h00, 5'd0, 7'd0, 1'b1);

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					phase_blank = 8'($urandom_range(1, 254));
				end
				1: begin
					phase_blank = 8'hFF;
				end
				2: begin
					phase_blank = 8'h00;
				end
				default: begin
					phase_blank = 8'($urandom);
				end
			endcase
			set_blank_attr(phase_blank);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 1 && n == 60) begin
					hold_off_request = 1'b1;
					repeat (30) random_req(1'b0);
				end
				if (phase == 2 && n == 75) begin
					wait_idle();
				end
				random_req((n / 40) % 3 != 2);
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

[files.f]
rtl/tccs_pkg.sv
rtl/tccs_ram.sv
rtl/tccs_cursor.sv
rtl/text_console_cursor_scroll_unit.sv
test/tb_text_console_cursor_scroll_unit.sv
